### rtl/bhrp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhrp_pkg
// Shared types and widths of the binary HEX record parser.
// ----------------------------------------------------------------------------
package bhrp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IndexW  = 9;
  localparam int unsigned NumberW = 16;

  typedef enum logic [1:0] {
    KIND_STORED = 2'd0,
    KIND_GOOD   = 2'd1,
    KIND_BAD    = 2'd2
  } kind_e;

endpackage
`default_nettype wire

### rtl/bhrp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhrp_in_if / bhrp_out_if
// Valid/ready channels of the parser: payload bytes in, record results out.
// ----------------------------------------------------------------------------
interface bhrp_in_if
  import bhrp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             packet_end;
  logic             restart;

  modport source (output valid, data_byte, packet_end, restart, input ready);
  modport sink   (input valid, data_byte, packet_end, restart, output ready);
endinterface

interface bhrp_out_if
  import bhrp_pkg::*;
();
  logic               valid;
  logic               ready;
  kind_e              kind;
  logic [IndexW-1:0]  byte_index;
  logic [ByteW-1:0]   byte_value;
  logic [NumberW-1:0] record_number;

  modport source (output valid, kind, byte_index, byte_value, record_number, input ready);
  modport sink   (input valid, kind, byte_index, byte_value, record_number, output ready);
endinterface
`default_nettype wire

### rtl/binary_hex_record_parser_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_hex_record_parser_top
// Hunts for ':' in packet payload bytes, reports each record byte, checks
// the 8-bit sum, reports bad records and good ones with their 16-bit number.
// ----------------------------------------------------------------------------
//  channel  dir  transaction
//  in_i     in   one payload byte: data_byte, packet_end, restart
//  out_o    out  one result: kind, byte_index, byte_value, record_number
//
//  One byte per cycle sustained while out_o is not stalled; a byte's result
//  is presented on out_o through the input register, then the state update
//  into the result register.
//  rst_ni clears the parser to hunting and empties both registers.
//  A stalled result holds the state step; one more byte waits in the input
//  register, so in_i.ready drops only while both are full and out is stalled.
// ----------------------------------------------------------------------------
module binary_hex_record_parser_top
  import bhrp_pkg::*;
(
  input  wire            clk_i,
  input  wire            rst_ni,
  bhrp_in_if.sink        in_i,
  bhrp_out_if.source     out_o
);

  localparam logic [ByteW-1:0] StartMark = 8'h3A;

  typedef enum logic [9:0] {
    PH_HUNT  = 10'b00_0000_0001,
    PH_LEN   = 10'b00_0000_0010,
    PH_ADDR1 = 10'b00_0000_0100,
    PH_ADDR0 = 10'b00_0000_1000,
    PH_TYPE  = 10'b00_0001_0000,
    PH_DATA  = 10'b00_0010_0000,
    PH_CSUM  = 10'b00_0100_0000,
    PH_NUM1  = 10'b00_1000_0000,
    PH_NUM2  = 10'b01_0000_0000,
    PH_SKIP  = 10'b10_0000_0000
  } phase_e;

  // input register
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_end_q;
  logic             in_rst_q;
  logic             adv;

  // parser state
  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  left_q, left_d;
  logic              empty_q, empty_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic [IndexW-1:0] sidx_q, sidx_d;
  logic [ByteW-1:0]  nhigh_q, nhigh_d;

  // result
  logic               res_vld;
  kind_e              res_kind;
  logic [IndexW-1:0]  res_idx;
  logic [ByteW-1:0]   res_val;
  logic [NumberW-1:0] res_num;
  logic               done;
  logic [ByteW-1:0]   sum_next;

  logic               out_vld_q;
  kind_e              out_kind_q;
  logic [IndexW-1:0]  out_idx_q;
  logic [ByteW-1:0]   out_val_q;
  logic [NumberW-1:0] out_num_q;

  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;
  assign sum_next   = sum_q + in_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_end_q  <= in_i.packet_end;
      in_rst_q  <= in_i.restart;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    empty_d  = empty_q;
    sum_d    = sum_q;
    sidx_d   = sidx_q;
    nhigh_d  = nhigh_q;
    res_vld  = 1'b0;
    res_kind = KIND_STORED;
    res_idx  = sidx_q;
    res_val  = in_byte_q;
    res_num  = '0;
    done     = 1'b0;

    if (in_rst_q) begin
      phase_d = PH_HUNT;
      left_d  = '0;
      empty_d = 1'b0;
      sum_d   = '0;
      sidx_d  = '0;
      nhigh_d = '0;
    end else begin
      unique case (phase_q)
        PH_LEN: begin
          left_d  = in_byte_q;
          empty_d = (in_byte_q == '0);
          sum_d   = in_byte_q;
          sidx_d  = IndexW'(1);
          nhigh_d = '0;
          res_idx = '0;
          res_vld = 1'b1;
          phase_d = PH_ADDR1;
        end
        PH_ADDR1, PH_ADDR0, PH_TYPE, PH_DATA: begin
          sum_d   = sum_next;
          sidx_d  = sidx_q + IndexW'(1);
          res_vld = 1'b1;
          if (phase_q == PH_ADDR1) begin
            phase_d = PH_ADDR0;
          end else if (phase_q == PH_ADDR0) begin
            phase_d = PH_TYPE;
          end else if (phase_q == PH_TYPE) begin
            phase_d = empty_q ? PH_CSUM : PH_DATA;
          end else begin
            left_d = left_q - ByteW'(1);
            if (left_q == ByteW'(1)) begin
              phase_d = PH_CSUM;
            end
          end
        end
        PH_CSUM: begin
          res_vld = 1'b1;
          if (sum_next == '0) begin
            sum_d   = sum_next;
            sidx_d  = sidx_q + IndexW'(1);
            phase_d = PH_NUM1;
          end else begin
            res_kind = KIND_BAD;
            done     = 1'b1;
          end
        end
        PH_NUM1: begin
          nhigh_d = in_byte_q;
          phase_d = PH_NUM2;
        end
        PH_NUM2: begin
          res_vld  = 1'b1;
          res_kind = KIND_GOOD;
          res_idx  = '0;
          res_val  = '0;
          res_num  = {nhigh_q, in_byte_q};
          done     = 1'b1;
        end
        PH_SKIP: begin
          if (in_end_q) begin
            phase_d = PH_HUNT;
          end
        end
        default: begin
          phase_d = (in_byte_q == StartMark) ? PH_LEN : PH_HUNT;
        end
      endcase

      if (done) begin
        left_d  = '0;
        empty_d = 1'b0;
        sum_d   = '0;
        sidx_d  = '0;
        nhigh_d = '0;
        phase_d = in_end_q ? PH_HUNT : PH_SKIP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      left_q    <= '0;
      empty_q   <= 1'b0;
      sum_q     <= '0;
      sidx_q    <= '0;
      nhigh_q   <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      phase_q   <= phase_d;
      left_q    <= left_d;
      empty_q   <= empty_d;
      sum_q     <= sum_d;
      sidx_q    <= sidx_d;
      nhigh_q   <= nhigh_d;
      out_vld_q <= res_vld;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_vld) begin
      out_kind_q <= res_kind;
      out_idx_q  <= res_idx;
      out_val_q  <= res_val;
      out_num_q  <= res_num;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.kind          = out_kind_q;
  assign out_o.byte_index    = out_idx_q;
  assign out_o.byte_value    = out_val_q;
  assign out_o.record_number = out_num_q;

endmodule
`default_nettype wire
